// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");
// Next-cycle implication that is checked during reset as well.
`define ASSERT_NEXT_ALWAYS(label, clk, a, b) \
  label: assert property (@(posedge clk) (a) |=> (b)) \
    else $error("assertion failed");
`endif

// File: rtl/core/pnog_pkg.sv
// Shared types and constants of the Perlin noise octave generator.
`timescale 1ns / 1ps
package pnog_pkg;
  localparam int TABLE_SIZE = 256;
  localparam int TBL_AW = 8;
  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_NOISE = 2'd1;
  localparam logic [1:0] MODE_OCTAVE = 2'd2;
  localparam logic [4:0] STEP_LAST = 5'd22;

  typedef struct packed {
    logic       accept;
    logic       setup;
    logic       eval;
    logic [4:0] step;
    logic [2:0] oct;
    logic       out_load;
  } pnog_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
  } pnog_status_t;
endpackage

// File: rtl/core/pnog_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module pnog_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;
endmodule

// File: rtl/core/pnog_ctrl.sv
// Controller state machine that sequences loads, noise evaluations and octaves.
`timescale 1ns / 1ps
module pnog_ctrl import pnog_pkg::*; #(
  parameter int OCTAVES = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic [1:0]   in_tuser,
  output logic         in_tready,
  output logic         out_tvalid,
  input  logic         out_tready,
  input  pnog_status_t status,
  output pnog_cmd_t    cmd
);
  typedef enum logic [1:0] {IDLE, SETUP, EVAL, FINISH} state_t;

  state_t     state_r;
  logic [4:0] step_r;
  logic [2:0] oct_r;
  logic       out_valid_r;
  logic       out_free;

  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd.accept = in_tvalid && (state_r == IDLE);
    cmd.setup = (state_r == SETUP);
    cmd.eval = (state_r == EVAL);
    cmd.step = step_r;
    cmd.oct = oct_r;
    cmd.out_load = (state_r == FINISH) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
      step_r <= '0;
      oct_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // In FINISH the result register is either reloaded or still held.
      if (out_valid_r && out_tready && state_r != FINISH) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        IDLE: begin
          if (in_tvalid) begin
            oct_r <= '0;
            if (in_tuser inside {MODE_NOISE, MODE_OCTAVE}) begin
              state_r <= SETUP;
            end else begin
              state_r <= FINISH;
            end
          end
        end
        SETUP: begin
          step_r <= '0;
          state_r <= EVAL;
        end
        EVAL: begin
          if (step_r == STEP_LAST) begin
            if (status.mode == MODE_OCTAVE && oct_r != 3'(OCTAVES - 1)) begin
              oct_r <= oct_r + 3'd1;
              state_r <= SETUP;
            end else begin
              state_r <= FINISH;
            end
          end else begin
            step_r <= step_r + 5'd1;
          end
        end
        FINISH: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r <= IDLE;
          end
        end
        default: state_r <= IDLE;
      endcase
    end
  end
endmodule

// File: rtl/core/pnog_dp.sv
// Datapath: cell setup, hashing through the table, fade, gradients, lerps, octave sum.
`timescale 1ns / 1ps
module pnog_dp import pnog_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  pnog_cmd_t    cmd,
  output pnog_status_t status,
  input  logic [111:0] in_tdata,
  input  logic [1:0]   in_tuser,
  output logic [31:0]  out_tdata,
  output logic         out_tuser
);
  localparam int F = FRAC_BITS;
  localparam int G = F + 4;
  localparam int ACC_W = (G + 2 > 33) ? G + 2 : 33;
  localparam logic signed [G-1:0] ONE = G'(1) <<< F;
  localparam logic signed [ACC_W-1:0] SMAX = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [ACC_W-1:0] SMIN = {{(ACC_W-31){1'b1}}, {31{1'b0}}};

  logic [1:0] mode_r;
  logic signed [31:0] x_r, y_r, z_r;
  logic [7:0] cx_r, cy_r, cz_r;
  logic [F-1:0] fx_r, fy_r, fz_r;
  logic [F:0] u_r, v_r, w_r;
  logic [F-1:0] t2_r, t3_r;
  logic [7:0] a_r, b_r, aa_r, ab_r, ba_r, bb_r;
  logic [3:0] h_r [8];
  logic signed [G-1:0] l_r [4];
  logic signed [G-1:0] n0_r, n1_r, nz_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [31:0] out_data_r;
  logic out_load_r;

  logic ram_we;
  logic [TBL_AW-1:0] ram_addr;
  logic [7:0] ram_rdata;

  pnog_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(in_tdata[111:104]),
    .rdata(ram_rdata)
  );

  assign ram_we = cmd.accept && (in_tuser == MODE_LOAD);
  assign status.mode = mode_r;
  assign out_tdata = out_data_r;
  assign out_tuser = out_load_r;

  always_comb begin
    ram_addr = in_tdata[103:96];
    if (cmd.eval) begin
      case (cmd.step)
        5'd0: ram_addr = cx_r;
        5'd1: ram_addr = cx_r + 8'd1;
        5'd2: ram_addr = a_r;
        5'd3: ram_addr = a_r + 8'd1;
        5'd4: ram_addr = b_r;
        5'd5: ram_addr = b_r + 8'd1;
        5'd6: ram_addr = aa_r;
        5'd7: ram_addr = ba_r;
        5'd8: ram_addr = ab_r;
        5'd9: ram_addr = bb_r;
        5'd10: ram_addr = aa_r + 8'd1;
        5'd11: ram_addr = ba_r + 8'd1;
        5'd12: ram_addr = ab_r + 8'd1;
        5'd13: ram_addr = bb_r + 8'd1;
        default: ram_addr = cx_r;
      endcase
    end
  end

  // Coordinate of the current octave: x itself in noise mode, else 2x shifted right by 7 - octave.
  logic signed [32:0] sx, sy;
  always_comb begin
    if (mode_r == MODE_NOISE) begin
      sx = {x_r[31], x_r};
      sy = {y_r[31], y_r};
    end else begin
      sx = $signed({x_r, 1'b0}) >>> (3'd7 - cmd.oct);
      sy = $signed({y_r, 1'b0}) >>> (3'd7 - cmd.oct);
    end
  end

  // Fade unit: one multiply per step, three steps per axis.
  logic [1:0] fd_axis;
  logic [1:0] fd_phase;
  logic [F-1:0] fd_t;
  logic signed [F+5:0] poly;
  logic [2*F-1:0] sq;
  logic [2*F+5:0] fprod;
  always_comb begin
    fd_axis = 2'd0;
    fd_phase = 2'd0;
    case (cmd.step)
      5'd0: begin fd_axis = 2'd0; fd_phase = 2'd0; end
      5'd1: begin fd_axis = 2'd0; fd_phase = 2'd1; end
      5'd2: begin fd_axis = 2'd0; fd_phase = 2'd2; end
      5'd3: begin fd_axis = 2'd1; fd_phase = 2'd0; end
      5'd4: begin fd_axis = 2'd1; fd_phase = 2'd1; end
      5'd5: begin fd_axis = 2'd1; fd_phase = 2'd2; end
      5'd6: begin fd_axis = 2'd2; fd_phase = 2'd0; end
      5'd7: begin fd_axis = 2'd2; fd_phase = 2'd1; end
      5'd8: begin fd_axis = 2'd2; fd_phase = 2'd2; end
      default: fd_phase = 2'd3;
    endcase
    case (fd_axis)
      2'd0: fd_t = fx_r;
      2'd1: fd_t = fy_r;
      default: fd_t = fz_r;
    endcase
    sq = (fd_phase == 2'd0) ? fd_t * fd_t : t2_r * fd_t;
    poly = (F+6)'(6) * $signed({6'b0, t2_r}) + ((F+6)'(10) <<< F)
           - (F+6)'(15) * $signed({6'b0, fd_t});
    fprod = {6'b0, t3_r} * poly[F+5:0];
  end

  function automatic logic signed [G-1:0] grad(input logic [3:0] h,
      input logic signed [G-1:0] gx, input logic signed [G-1:0] gy,
      input logic signed [G-1:0] gz);
    logic signed [G-1:0] gu, gv;
    gu = (h < 4'd8) ? gx : gy;
    gv = (h < 4'd4) ? gy : ((h == 4'd12 || h == 4'd14) ? gx : gz);
    if (h[0]) gu = -gu;
    if (h[1]) gv = -gv;
    return gu + gv;
  endfunction

  logic signed [G-1:0] px, py, pz, qx, qy, qz;
  assign px = $signed({{(G-F){1'b0}}, fx_r});
  assign py = $signed({{(G-F){1'b0}}, fy_r});
  assign pz = $signed({{(G-F){1'b0}}, fz_r});
  assign qx = px - ONE;
  assign qy = py - ONE;
  assign qz = pz - ONE;

  // Shared lerp unit: a + floor(t * (b - a) / 2^F).
  logic [F:0] lt;
  logic signed [G-1:0] la, lb, lres;
  logic signed [G:0] ldiff;
  logic signed [F+G+1:0] lprod, lshift;
  always_comb begin
    lt = u_r;
    la = '0;
    lb = '0;
    case (cmd.step)
      5'd15: begin la = grad(h_r[0], px, py, pz); lb = grad(h_r[1], qx, py, pz); end
      5'd16: begin la = grad(h_r[2], px, qy, pz); lb = grad(h_r[3], qx, qy, pz); end
      5'd17: begin la = grad(h_r[4], px, py, qz); lb = grad(h_r[5], qx, py, qz); end
      5'd18: begin la = grad(h_r[6], px, qy, qz); lb = grad(h_r[7], qx, qy, qz); end
      5'd19: begin lt = v_r; la = l_r[0]; lb = l_r[1]; end
      5'd20: begin lt = v_r; la = l_r[2]; lb = l_r[3]; end
      5'd21: begin lt = w_r; la = n0_r; lb = n1_r; end
      default: lt = u_r;
    endcase
    ldiff = $signed({lb[G-1], lb}) - $signed({la[G-1], la});
    lprod = $signed({1'b0, lt}) * ldiff;
    lshift = lprod >>> F;
    lres = la + lshift[G-1:0];
  end

  logic signed [ACC_W-1:0] term;
  assign term = $signed({{(ACC_W-G){nz_r[G-1]}}, nz_r}) >>> cmd.oct;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r <= in_tuser;
      x_r <= in_tdata[31:0];
      y_r <= in_tdata[63:32];
      z_r <= in_tdata[95:64];
      acc_r <= '0;
    end
    if (cmd.setup) begin
      cx_r <= sx[F+7:F];
      fx_r <= sx[F-1:0];
      cy_r <= sy[F+7:F];
      fy_r <= sy[F-1:0];
      if (mode_r == MODE_NOISE) begin
        cz_r <= z_r[F+7:F];
        fz_r <= z_r[F-1:0];
      end else begin
        cz_r <= 8'd128;
        fz_r <= '0;
      end
    end
    if (cmd.eval) begin
      case (fd_phase)
        2'd0: t2_r <= sq[2*F-1:F];
        2'd1: t3_r <= sq[2*F-1:F];
        2'd2: begin
          case (fd_axis)
            2'd0: u_r <= fprod[2*F:F];
            2'd1: v_r <= fprod[2*F:F];
            default: w_r <= fprod[2*F:F];
          endcase
        end
        default: ;
      endcase
      case (cmd.step)
        5'd1: a_r <= ram_rdata + cy_r;
        5'd2: b_r <= ram_rdata + cy_r;
        5'd3: aa_r <= ram_rdata + cz_r;
        5'd4: ab_r <= ram_rdata + cz_r;
        5'd5: ba_r <= ram_rdata + cz_r;
        5'd6: bb_r <= ram_rdata + cz_r;
        5'd7: h_r[0] <= ram_rdata[3:0];
        5'd8: h_r[1] <= ram_rdata[3:0];
        5'd9: h_r[2] <= ram_rdata[3:0];
        5'd10: h_r[3] <= ram_rdata[3:0];
        5'd11: h_r[4] <= ram_rdata[3:0];
        5'd12: h_r[5] <= ram_rdata[3:0];
        5'd13: h_r[6] <= ram_rdata[3:0];
        5'd14: h_r[7] <= ram_rdata[3:0];
        5'd15: l_r[0] <= lres;
        5'd16: l_r[1] <= lres;
        5'd17: l_r[2] <= lres;
        5'd18: l_r[3] <= lres;
        5'd19: n0_r <= lres;
        5'd20: n1_r <= lres;
        5'd21: nz_r <= lres;
        5'd22: acc_r <= acc_r + term;
        default: ;
      endcase
    end
    if (cmd.out_load) begin
      out_load_r <= (mode_r == MODE_LOAD);
      if (mode_r == MODE_NOISE || mode_r == MODE_OCTAVE) begin
        if (acc_r > SMAX) out_data_r <= 32'h7fffffff;
        else if (acc_r < SMIN) out_data_r <= 32'h80000000;
        else out_data_r <= acc_r[31:0];
      end else begin
        out_data_r <= '0;
      end
    end
  end
endmodule

// File: rtl/core/perlin_noise_octave_generator.sv
// Top level of the Perlin noise octave generator: controller, datapath and table.
// The result of a load or an ignored request is registered in the finish state once
// the output is free. A 3D noise request makes one evaluation, an octave request one
// per octave. One request is worked on at a time; an evaluation is a setup state and
// 23 steps of the single-port permutation table and shared fade and lerp multipliers.
// Reset (rst_n low, synchronous) clears control state; table contents are undefined.
`timescale 1ns / 1ps
module perlin_noise_octave_generator import pnog_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int OCTAVES = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // Fields from bit 0: coord_x[31:0], coord_y[63:32], coord_z[95:64],
  // table_index[103:96], table_value[111:104].
  input  logic [111:0] in_tdata,
  // Fields from bit 0: mode[1:0].
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // Fields from bit 0: noise_value[31:0].
  output logic [31:0]  out_tdata,
  // Fields from bit 0: was_load[0].
  output logic         out_tuser
);
  // The controller hands one command word per cycle to the datapath and
  // reads back the mode of the request in flight.
  pnog_cmd_t    cmd;
  pnog_status_t status;

  pnog_ctrl #(.OCTAVES(OCTAVES)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tuser(in_tuser),
    .in_tready(in_tready), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .status(status), .cmd(cmd)
  );

  // The datapath owns the table, the coordinate and hash registers, and the
  // result register that holds a finished result until it is taken.
  pnog_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .cmd(cmd), .status(status), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .out_tdata(out_tdata), .out_tuser(out_tuser)
  );
endmodule

// File: rtl/core/pnog_checker.sv
// Port-level checker for the Perlin noise octave generator, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pnog_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [31:0]  out_tdata,
  input logic         out_tuser
);
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `ASSERT_IMPLY(a_load_zero, clk, rst_n, out_tvalid && out_tuser, out_tdata == 32'd0)
  `ASSERT_NEXT(a_busy_after, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `ASSERT_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_tvalid)
endmodule

bind perlin_noise_octave_generator pnog_checker u_pnog_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser)
);
